/* src/sirs_pkg.sv */
// Shared types, character codes and register map for the radix symbol unit.
// Depends on nothing; every other file of the unit but sirs_div_step imports it.
`default_nettype none

package sirs_pkg;

    // Fixed sizes of the alphabet and of the digit store.
    localparam int SYM_COUNT       = 32;
    localparam int SYM_IDX_W       = 5;
    localparam int DIGIT_DEPTH     = 32;
    localparam int DEF_MAX_SYMBOLS = 32;

    // Characters that may not appear in an alphabet.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CTRL_LO    = 8'd9;
    localparam logic [7:0] CTRL_HI    = 8'd13;
    localparam logic [5:0] MIN_RADIX  = 6'd2;

    // Register indexes (byte address is eight times the index).
    localparam logic [2:0] REG_RADIX_LENGTH     = 3'd0;
    localparam logic [2:0] REG_SYMBOLS_LOW      = 3'd1;
    localparam logic [2:0] REG_SYMBOLS_MID_LOW  = 3'd2;
    localparam logic [2:0] REG_SYMBOLS_MID_HIGH = 3'd3;
    localparam logic [2:0] REG_SYMBOLS_HIGH     = 3'd4;

    typedef logic [SYM_COUNT-1:0][7:0] symbol_table_t;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic [5:0]    radix;
        symbol_table_t symbols;
    } cfg_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CHECK   = 6'b000010,
        ST_DIVIDE  = 6'b000100,
        ST_SIGN    = 6'b001000,
        ST_EMIT_RD = 6'b010000,
        ST_EMIT_LD = 6'b100000
    } state_t;

    // True for a byte that is not allowed as an alphabet symbol.
    function automatic logic symbol_forbidden(input logic [7:0] s);
        return (s == CHAR_NUL) || (s == CHAR_PLUS) || (s == CHAR_MINUS) ||
               (s == CHAR_SPACE) || ((s >= CTRL_LO) && (s <= CTRL_HI));
    endfunction

endpackage

`default_nettype wire

/* src/sirs_cfg_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on sirs_pkg for the register map and the cfg_t type.
`default_nettype none

module sirs_cfg_regs
    import sirs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [5:0]  radix_reg;
    logic [63:0] sym_low_reg;
    logic [63:0] sym_mid_low_reg;
    logic [63:0] sym_mid_high_reg;
    logic [63:0] sym_high_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; an index beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= '0;
            sym_low_reg      <= '0;
            sym_mid_low_reg  <= '0;
            sym_mid_high_reg <= '0;
            sym_high_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RADIX_LENGTH:     radix_reg        <= pwdata[5:0];
                REG_SYMBOLS_LOW:      sym_low_reg      <= pwdata;
                REG_SYMBOLS_MID_LOW:  sym_mid_low_reg  <= pwdata;
                REG_SYMBOLS_MID_HIGH: sym_mid_high_reg <= pwdata;
                REG_SYMBOLS_HIGH:     sym_high_reg     <= pwdata;
                default:              ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            REG_RADIX_LENGTH:     prdata = {58'd0, radix_reg};
            REG_SYMBOLS_LOW:      prdata = sym_low_reg;
            REG_SYMBOLS_MID_LOW:  prdata = sym_mid_low_reg;
            REG_SYMBOLS_MID_HIGH: prdata = sym_mid_high_reg;
            REG_SYMBOLS_HIGH:     prdata = sym_high_reg;
            default:              prdata = '0;
        endcase
    end

    // Symbol 0 sits in the low byte of the low register.
    assign cfg.radix   = radix_reg;
    assign cfg.symbols = {sym_high_reg, sym_mid_high_reg, sym_mid_low_reg, sym_low_reg};

endmodule

`default_nettype wire

/* src/sirs_div_step.sv */
// Shared divider step: eight restoring division bits by the radix per cycle.
// Depends on nothing but its ports; the sequencer registers its results.
`default_nettype none

module sirs_div_step (
    input  wire logic [5:0] radix,
    input  wire logic [4:0] rem_in,
    input  wire logic [7:0] dividend,
    output logic      [4:0] rem_out,
    output logic      [7:0] quot_out
);

    // The remainder stays below the radix, so five bits hold it and the
    // trial value never exceeds six bits.
    always_comb
    begin
        logic [5:0] trial;
        logic [4:0] rem;
        rem      = rem_in;
        quot_out = '0;
        for (int i = 7; i >= 0; i--)
        begin
            trial = {rem, dividend[i]};
            if (trial >= radix)
            begin
                quot_out[i] = 1'b1;
                rem         = 5'(trial - radix);
            end
            else
            begin
                rem = trial[4:0];
            end
        end
        rem_out = rem;
    end

endmodule

`default_nettype wire

/* src/sirs_seq.sv */
// Sequencer: alphabet check, digit extraction through the shared divider step,
// digit store and output register. Depends on sirs_pkg and sirs_div_step.
`default_nettype none

module sirs_seq
    import sirs_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic signed [31:0] value,
    input  wire logic               value_valid,
    output logic                    value_ready,
    output logic             [7:0]  symbol,
    output logic                    last,
    output logic                    symbol_valid,
    input  wire logic               symbol_ready
);

    state_t         state_reg, state_next;
    logic           neg_reg, neg_next;
    logic [31:0]    quot_reg, quot_next;
    logic [4:0]     rem_reg, rem_next;
    logic [1:0]     step_reg, step_next;
    logic [4:0]     idx_reg, idx_next;
    logic [5:0]     count_reg, count_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     symbol_reg, symbol_next;
    logic           last_reg, last_next;
    logic [4:0]     rd_data_reg;

    logic [4:0]     digit_mem [DIGIT_DEPTH];
    logic           mem_we;
    logic           mem_re;
    logic [4:0]     mem_raddr;

    logic           accept;
    logic           out_free;
    logic           radix_bad;
    logic           sym_bad;
    logic [7:0]     cur_sym;
    logic [4:0]     div_rem;
    logic [7:0]     div_quot;
    logic [31:0]    quot_shifted;
    logic [31:0]    value_u;

    assign value_ready  = (state_reg == ST_IDLE);
    assign accept       = value_valid && value_ready;
    assign out_free     = !out_valid_reg || symbol_ready;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign symbol_valid = out_valid_reg;
    assign value_u      = unsigned'(value);

    // Shared divider step, fed with the top byte of the running quotient.
    sirs_div_step u_div_step (
        .radix    (cfg.radix),
        .rem_in   (rem_reg),
        .dividend (quot_reg[31:24]),
        .rem_out  (div_rem),
        .quot_out (div_quot)
    );

    assign quot_shifted = {quot_reg[23:0], div_quot};

    // Alphabet check of one symbol per cycle against all later symbols in use.
    assign radix_bad = (cfg.radix < MIN_RADIX) || (cfg.radix > 6'(MAX_SYMBOLS));
    assign cur_sym   = cfg.symbols[idx_reg];

    always_comb
    begin
        sym_bad = symbol_forbidden(cur_sym);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((5'(j) > idx_reg) && (6'(j) < cfg.radix) && (cfg.symbols[j] == cur_sym))
            begin
                sym_bad = 1'b1;
            end
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !symbol_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = 5'(count_reg - 6'd1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[31];
                    quot_next  = value[31] ? (32'd0 - value_u) : value_u;
                    idx_next   = '0;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (radix_bad || sym_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if ({1'b0, idx_reg} == (cfg.radix - 6'd1))
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
            end

            ST_DIVIDE:
            begin
                quot_next = quot_shifted;
                rem_next  = div_rem;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    // One digit is complete: store it, least significant first.
                    mem_we     = 1'b1;
                    count_next = count_reg + 6'd1;
                    rem_next   = '0;
                    if ((quot_shifted == 32'd0) || (count_reg == 6'(DIGIT_DEPTH - 1)))
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT_RD;
                    end
                end
            end

            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = cfg.symbols[rd_data_reg];
                    last_next      = (count_reg == 6'd1);
                    count_next     = count_reg - 6'd1;
                    state_next     = (count_reg == 6'd1) ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    // Digit store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[count_reg[4:0]] <= div_rem;
        end
        if (mem_re)
        begin
            rd_data_reg <= digit_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/signed_int_to_radix_symbols_unit.sv */
// Top level of the signed integer to radix symbol unit.
// Depends on sirs_pkg, sirs_cfg_regs, sirs_div_step (via sirs_seq) and sirs_seq.
//
//   Channel   Signals                                   Direction  Width
//   config    psel penable pwrite paddr pwdata          in         1/1/1/6/64
//             prdata pready                             out        64/1
//   value     value value_valid / value_ready           in / out   32 signed
//   symbol    symbol last symbol_valid / symbol_ready   out / in   8, 1
//
// An accepted value first goes through the alphabet check, one symbol in
// use at a time, then each digit comes out of the divider step, which resolves
// eight quotient bits per cycle, then each symbol beat is read from the digit
// store and loaded, after a minus-sign beat for a negative value.
// value_ready is high only while the sequencer is idle; a stalled symbol beat
// holds the sequencer, and the final beat may wait while the next value enters.
// Reset is asynchronous and clears the configuration registers and the sequencer control state at once.
`default_nettype none

module signed_int_to_radix_symbols_unit
    import sirs_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [5:0]  paddr,
    input  wire logic        [63:0] pwdata,
    output logic             [63:0] prdata,
    output logic                    pready,
    input  wire logic signed [31:0] value,
    input  wire logic               value_valid,
    output logic                    value_ready,
    output logic             [7:0]  symbol,
    output logic                    last,
    output logic                    symbol_valid,
    input  wire logic               symbol_ready
);

    cfg_t cfg;

    // Configuration registers.
    sirs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Conversion sequencer.
    sirs_seq #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .value        (value),
        .value_valid  (value_valid),
        .value_ready  (value_ready),
        .symbol       (symbol),
        .last         (last),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready)
    );

endmodule

`default_nettype wire

/* src/sirs_checker.sv */
// Port-level checks of the radix symbol unit, attached by a bind statement.
// Depends on sirs_pkg for character codes.
`default_nettype none

module sirs_checker
    import sirs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        value_valid,
    input wire logic        value_ready,
    input wire logic [7:0]  symbol,
    input wire logic        last,
    input wire logic        symbol_valid,
    input wire logic        symbol_ready
);

    // A stalled symbol beat keeps its payload.
    a_symbol_hold: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_ready |=> symbol_valid && $stable(symbol) && $stable(last))
        else $error("symbol beat changed while stalled");

    // Once a value is taken, the unit is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> !value_ready)
        else $error("value accepted on consecutive cycles");

    // The minus sign only ever opens a number, so it never ends one.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && (symbol == CHAR_MINUS) |-> !last)
        else $error("minus sign marked as last symbol");

    // A valid alphabet holds no zero byte, so no beat carries one.
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid |-> (symbol != CHAR_NUL))
        else $error("zero byte emitted as symbol");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind signed_int_to_radix_symbols_unit sirs_checker u_sirs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .value_valid  (value_valid),
    .value_ready  (value_ready),
    .symbol       (symbol),
    .last         (last),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready)
);

`default_nettype wire
